[rtl/core/bpa_pkg.sv]
// Shared constants and types for the bitmap page allocator.
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;
  localparam int MaxPages = 65536;
  localparam int WordBits = 64;
  localparam int Words = MaxPages / WordBits;
  localparam int WordAw = $clog2(Words);
  localparam int ChunkBits = 8;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BOUNDS = 2'd2;

  localparam logic OP_CLAIM = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic en;
    logic we;
    logic [WordAw-1:0] addr;
    logic [WordBits-1:0] wdata;
  } mem_req_t;
endpackage
`default_nettype wire

[rtl/core/bpa_bitmap.sv]
// Bitmap store: one 64-bit word of used bits per access, registered read.
`timescale 1ns / 1ps
`default_nettype none
module bpa_bitmap (
  input  wire logic                           clk,
  input  wire bpa_pkg::mem_req_t              req,
  output logic [bpa_pkg::WordBits-1:0]        rdata
);
  logic [bpa_pkg::WordBits-1:0] mem [bpa_pkg::Words];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/bitmap_page_allocator.sv]
// Top level: next-fit contiguous page allocator over a word-wide bitmap.
`timescale 1ns / 1ps
`default_nettype none
// After reset the block sweeps all 1024 words of the bitmap to used, with busy
// high. An item is taken when start is high and busy low. A claim walks the
// bitmap one 64-bit word at a time through the single memory port: a word
// that is all used, or wholly free with the run still short, is skipped whole
// after its read; any other word is scanned eight bits a cycle. A full search
// makes at most two passes. Marking or clearing a run reads and then writes
// each word it touches. One result per item appears for one cycle with
// result_valid; the receiver cannot stall it.
module bitmap_page_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation,
  input  wire logic [15:0] page_index,
  input  wire logic [16:0] page_count,
  output logic             result_valid,
  output logic [1:0]       status,
  output logic [15:0]      start_page,
  output logic [16:0]      pages_in_use,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_data
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_MRD   = 3'd4;
  localparam logic [2:0] S_MWR   = 3'd5;

  localparam int Aw = bpa_pkg::WordAw;
  localparam int Wb = bpa_pkg::WordBits;

  logic [2:0]    state;
  logic [16:0]   total_pages;
  logic [16:0]   tp;
  logic [Aw-1:0] clr_addr;
  logic [16:0]   pos;
  logic [16:0]   run;
  logic [16:0]   cnt;
  logic          pass;
  logic [15:0]   next_index;
  logic [16:0]   in_use_count;
  logic [16:0]   hi;
  logic          set_val;
  logic [15:0]   res_start;
  bpa_pkg::mem_req_t req;
  logic [Wb-1:0] rdata;

  // chunk scan
  logic [16:0] run_c;
  logic        found_c;
  logic [15:0] last_c;
  logic [16:0] p_c;
  logic [6:0]  off_c;
  logic [16:0] pos_adv;
  logic        fast_ok;
  logic [17:0] run64;
  logic [Wb-1:0] mask;
  logic [16:0] pg;
  logic [16:0] mpos_next;
  logic [17:0] rel_end;
  logic [17:0] sat_add;

  assign tp = (total_pages > 17'(bpa_pkg::MaxPages)) ? 17'(bpa_pkg::MaxPages) : total_pages;
  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign pages_in_use = in_use_count;
  assign rel_end = {2'b0, page_index} + {1'b0, page_count};
  assign run64 = {1'b0, run} + 18'd64;
  assign fast_ok = (pos[5:0] == 6'd0) && ({1'b0, pos} + 18'd64 <= {1'b0, tp});
  assign sat_add = {1'b0, in_use_count} + {1'b0, cnt};
  assign mpos_next = {pos[16:6] + 11'd1, 6'd0};

  bpa_bitmap u_bitmap (.clk(clk), .req(req), .rdata(rdata));

  always_comb begin
    run_c = run;
    found_c = 1'b0;
    last_c = '0;
    pos_adv = pos;
    p_c = pos;
    off_c = '0;
    for (int i = 0; i < bpa_pkg::ChunkBits; i++) begin
      p_c = pos + 17'(i);
      off_c = {1'b0, pos[5:0]} + 7'(i);
      if (!off_c[6]) begin
        pos_adv = p_c + 17'd1;
        if (p_c < tp && !found_c) begin
          if (rdata[off_c[5:0]]) begin
            run_c = '0;
          end else begin
            run_c = run_c + 17'd1;
            if (run_c == cnt) begin
              found_c = 1'b1;
              last_c = p_c[15:0];
            end
          end
        end
      end
    end
  end

  always_comb begin
    pg = '0;
    for (int b = 0; b < Wb; b++) begin
      pg = {pos[16:6], 6'(b)};
      mask[b] = (pg >= pos) && (pg <= hi);
    end
  end

  always_comb begin
    req = '0;
    case (state)
      S_CLEAR: begin
        req.en = 1'b1;
        req.we = 1'b1;
        req.addr = clr_addr;
        req.wdata = '1;
      end
      S_RD, S_MRD: begin
        req.en = (state == S_MRD) || (pos < tp);
        req.addr = pos[Aw+5:6];
      end
      S_MWR: begin
        req.en = 1'b1;
        req.we = 1'b1;
        req.addr = pos[Aw+5:6];
        req.wdata = set_val ? (rdata | mask) : (rdata & ~mask);
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      total_pages <= 17'(bpa_pkg::MaxPages);
      next_index <= '0;
      in_use_count <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        total_pages <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cnt <= page_count;
            res_start <= '0;
            if (operation == bpa_pkg::OP_CLAIM) begin
              if (page_count == '0 || page_count > tp) begin
                status <= bpa_pkg::ST_NO_SPACE;
                start_page <= '0;
                result_valid <= 1'b1;
              end else begin
                pos <= {1'b0, next_index};
                run <= '0;
                pass <= 1'b0;
                state <= S_RD;
              end
            end else if (rel_end > {1'b0, tp}) begin
              status <= bpa_pkg::ST_BOUNDS;
              start_page <= '0;
              result_valid <= 1'b1;
            end else if (page_count == '0) begin
              status <= bpa_pkg::ST_DONE;
              start_page <= '0;
              result_valid <= 1'b1;
            end else begin
              pos <= {1'b0, page_index};
              hi <= 17'(rel_end - 18'd1);
              set_val <= 1'b0;
              in_use_count <= (in_use_count > page_count) ?
                              in_use_count - page_count : '0;
              state <= S_MRD;
            end
          end
        end
        S_RD: begin
          if (pos >= tp) begin
            if (!pass) begin
              next_index <= '0;
              pos <= '0;
              run <= '0;
              pass <= 1'b1;
            end else begin
              status <= bpa_pkg::ST_NO_SPACE;
              start_page <= '0;
              result_valid <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (fast_ok && rdata == '1) begin
            run <= '0;
            pos <= pos + 17'd64;
            state <= S_RD;
          end else if (fast_ok && rdata == '0 && run64 < {1'b0, cnt}) begin
            run <= run64[16:0];
            pos <= pos + 17'd64;
            state <= S_RD;
          end else if (found_c) begin
            res_start <= 16'(({1'b0, last_c} + 17'd1) - cnt);
            pos <= ({1'b0, last_c} + 17'd1) - cnt;
            hi <= {1'b0, last_c};
            next_index <= last_c;
            set_val <= 1'b1;
            in_use_count <= sat_add[17] ? 17'h1FFFF : sat_add[16:0];
            state <= S_MRD;
          end else begin
            run <= run_c;
            pos <= pos_adv;
            if (pos_adv[5:0] == 6'd0) begin
              state <= S_RD;
            end
          end
        end
        S_MRD: begin
          state <= S_MWR;
        end
        S_MWR: begin
          pos <= mpos_next;
          if (mpos_next > hi) begin
            status <= bpa_pkg::ST_DONE;
            start_page <= res_start;
            result_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_MRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result never carries the unused status code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status != 2'd3)) else $error("bad status code");
  // results only follow a busy cycle or an item taken straight from idle
  a_res_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(busy) || $past(start))) else $error("result without work");
  // a failed claim or release reports start page zero
  a_fail_start: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != bpa_pkg::ST_DONE) |-> (start_page == 16'd0))
    else $error("nonzero start on failure");
endmodule
`default_nettype wire

[test/bitmap_page_allocator_test.sv]
// Self-checking testbench for the bitmap page allocator.
`timescale 1ns / 1ps
module bitmap_page_allocator_test;
  import bpa_pkg::*;

  typedef struct {
    logic        op;
    logic [15:0] idx;
    logic [16:0] cnt;
  } page_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] start_page;
    logic [16:0] pages_in_use;
  } alloc_resp_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic operation = 0;
  logic [15:0] page_index = 0;
  logic [16:0] page_count = 0;
  logic result_valid;
  logic [1:0] status;
  logic [15:0] start_page;
  logic [16:0] pages_in_use;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [16:0] cfg_data = 0;

  bitmap_page_allocator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .page_index(page_index), .page_count(page_count),
    .result_valid(result_valid), .status(status), .start_page(start_page),
    .pages_in_use(pages_in_use), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  page_req_t   pending_reqs[$];
  alloc_resp_t expected_resps[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 0;
  bit no_idle = 0;

  // Shadow allocator state
  bit          shadow_used [0:MaxPages-1];
  int unsigned shadow_next;
  int unsigned shadow_in_use;
  int unsigned shadow_total;

  function automatic bit find_run(int unsigned from, int unsigned stop,
                                  int unsigned cnt, output int unsigned last);
    int unsigned run;
    run = 0;
    last = 0;
    for (int unsigned p = from; p < stop; p++) begin
      if (shadow_used[p]) run = 0;
      else begin
        run++;
        if (run == cnt) begin
          last = p;
          return 1;
        end
      end
    end
    return 0;
  endfunction

  function automatic alloc_resp_t alloc_predict(page_req_t r);
    alloc_resp_t rs;
    int unsigned tp, cnt, last;
    bit found;
    tp = (shadow_total > MaxPages) ? MaxPages : shadow_total;
    cnt = r.cnt;
    rs.status = ST_DONE;
    rs.start_page = 0;
    if (r.op == OP_CLAIM) begin
      found = 0;
      if (cnt != 0 && cnt <= tp) begin
        found = find_run(shadow_next, tp, cnt, last);
        if (!found) begin
          shadow_next = 0;
          found = find_run(0, tp, cnt, last);
        end
      end
      if (found) begin
        rs.start_page = 16'(last + 1 - cnt);
        for (int unsigned p = last + 1 - cnt; p <= last; p++) shadow_used[p] = 1;
        shadow_next = last;
        shadow_in_use = (shadow_in_use + cnt > 131071) ? 131071 : shadow_in_use + cnt;
      end else rs.status = ST_NO_SPACE;
    end else begin
      if (int'(r.idx) + cnt > tp) rs.status = ST_BOUNDS;
      else begin
        for (int unsigned p = 0; p < cnt; p++) shadow_used[r.idx + p] = 0;
        shadow_in_use = (shadow_in_use > cnt) ? shadow_in_use - cnt : 0;
      end
    end
    rs.pages_in_use = 17'(shadow_in_use);
    return rs;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 23);
  endfunction

  // Driver
  always @(posedge clk) begin
    page_req_t r;
    if (rst) start <= 0;
    else begin
      if (start && !busy) expected_resps.push_back(alloc_predict('{operation, page_index,
                                                                   page_count}));
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 && !hold_off && !idle_now()) begin
          r = pending_reqs.pop_front();
          operation <= r.op;
          page_index <= r.idx;
          page_count <= r.cnt;
          start <= 1;
        end else start <= 0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    alloc_resp_t e;
    if (!rst && result_valid) begin
      if (expected_resps.size() == 0) begin
        $error("unexpected result status=%0d start_page=%0d", status, start_page);
        errors++;
      end else begin
        e = expected_resps.pop_front();
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status);
          errors++;
        end
        if (start_page !== e.start_page) begin
          $error("start_page expected %0d actual %0d", e.start_page, start_page);
          errors++;
        end
        if (pages_in_use !== e.pages_in_use) begin
          $error("pages_in_use expected %0d actual %0d", e.pages_in_use, pages_in_use);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 50000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_item(logic op, int idx, int cnt);
    pending_reqs.push_back('{op, 16'(idx), 17'(cnt)});
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || start || expected_resps.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_total(int unsigned val);
    drain();
    while (busy) @(posedge clk);
    cfg_data <= 17'(val);
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    shadow_total = val;
  endtask

  // Random mix sized to the covered pages; claims mostly small and well formed
  task automatic random_items(int n, int unsigned tp);
    int unsigned idx, cnt, k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 50) begin
        cnt = (k < 3) ? 0 : (k < 6) ? tp + $urandom_range(3) : $urandom_range(1, tp < 8 ? tp : 8);
        push_item(OP_CLAIM, $urandom_range(65535), cnt);
      end else begin
        idx = (k < 55) ? $urandom_range(65535) : $urandom_range(tp - 1);
        if (idx > 65535) idx = 65535;
        cnt = (k < 60) ? $urandom_range(131071) :
              $urandom_range(0, (tp - idx < 12) ? tp - idx : 12);
        push_item(OP_RELEASE, idx, cnt);
      end
    end
  endtask

  initial begin
    for (int p = 0; p < MaxPages; p++) shadow_used[p] = 1;
    shadow_next = 0;
    shadow_in_use = 0;
    shadow_total = 65536;
    repeat (4) @(posedge clk);
    rst <= 0;

    write_total(65536);
    // everything reserved at first: claims fail until the whole range is released
    push_item(OP_CLAIM, 0, 0);
    push_item(OP_CLAIM, 0, 1);
    push_item(OP_RELEASE, 65535, 2);
    push_item(OP_RELEASE, 65535, 0);
    push_item(OP_RELEASE, 65535, 1);
    push_item(OP_RELEASE, 0, 65536);
    push_item(OP_CLAIM, 65535, 65536);
    push_item(OP_RELEASE, 0, 65536);
    push_item(OP_RELEASE, 100, 300);
    push_item(OP_RELEASE, 500, 4);
    push_item(OP_CLAIM, 0, 200);
    push_item(OP_CLAIM, 0, 150);
    push_item(OP_CLAIM, 0, 4);
    push_item(OP_CLAIM, 0, 3);
    push_item(OP_CLAIM, 0, 200);
    push_item(OP_RELEASE, 40000, 20);
    push_item(OP_CLAIM, 0, 16);
    push_item(OP_CLAIM, 0, 5);
    push_item(OP_RELEASE, 40000, 25536);
    push_item(OP_CLAIM, 0, 25536);
    random_items(30, 65536);

    // wait for the pipeline to empty before continuing
    drain();
    hold_off = 1;
    while (expected_resps.size() > 0) @(posedge clk);
    hold_off = 0;

    write_total(1);
    push_item(OP_RELEASE, 0, 1);
    push_item(OP_CLAIM, 0, 1);
    push_item(OP_CLAIM, 0, 2);
    push_item(OP_RELEASE, 1, 1);
    random_items(20, 1);

    write_total(64);
    push_item(OP_RELEASE, 0, 64);
    no_idle = 1;
    random_items(80, 64);
    drain();
    no_idle = 0;

    write_total(131071);
    random_items(10, 65536);

    write_total(200);
    push_item(OP_RELEASE, 0, 200);
    random_items(130, 200);

    write_total(1000);
    push_item(OP_RELEASE, 0, 1000);
    random_items(120, 1000);

    drain();
    if (errors == 0 && expected_resps.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
